// File: design/brf_pkg.sv
// Package for the blended raster fill engine: command kinds, register indexes
// and the per-channel divide-by-255 helper. No dependencies.
package brf_pkg;

    localparam logic [1:0] KIND_BLEND = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_CIRC  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int MUL_W = 18;

    typedef logic signed [MUL_W-1:0]   mul_op_t;
    typedef logic signed [2*MUL_W-1:0] mul_res_t;

    // Exact floor(v / 255) for v up to 65279, which covers every blend sum.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        return s[15:8];
    endfunction

endpackage

// File: design/blended_raster_fill.sv
// Blended raster fill engine: top level with sequencer, shared multiplier and
// frame memory. Depends on brf_pkg.
//
// Usage:
//  - Commands arrive on the s_ channel (valid/ready). One transaction carries
//    a kind (blend pixel, fill rectangle, fill circle, read pixel), position,
//    rectangle size, radius and RGBA color.
//  - Every command yields exactly one transaction on the m_ channel: pixel
//    data and an in-range flag for reads, zeros for drawing commands.
//  - cfg_wr_en/cfg_index/cfg_wr_data set the image size; write only while idle.
//  - After reset the frame memory is swept to zero, one pixel a cycle, with
//    s_ready low; the sweep covers MAX_WIDTH*MAX_HEIGHT pixels (4096 at the defaults).
//  - One command at a time. A single shared 18x18 multiplier does the address
//    computation, the circle distance test and the per-channel blend, so each
//    visited pixel steps through address, read, three channels, write and
//    advance; circles first add two distance squares. A read steps through
//    setup, address and read before its result is loaded.
//  - The result sits in an output register; the next command is accepted while
//    it waits. If the receiver stalls, the engine holds the following result
//    until the previous one is taken.
module blended_raster_fill
    import brf_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [15:0] s_x_pos,
    input  logic signed [15:0] s_y_pos,
    input  logic [14:0]        s_rect_width,
    input  logic [14:0]        s_rect_height,
    input  logic [14:0]        s_radius,
    input  logic [31:0]        s_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_read_data,
    output logic               m_read_in_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_DX    = 4'd3;
    localparam logic [3:0] ST_DY    = 4'd4;
    localparam logic [3:0] ST_ADDR  = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_CH    = 4'd7;
    localparam logic [3:0] ST_WR    = 4'd8;
    localparam logic [3:0] ST_NEXT  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [6:0]  width_cfg_reg, height_cfg_reg;

    // captured command
    logic [1:0]         kind_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [14:0]        rw_reg, rh_reg, rad_reg;
    logic [31:0]        color_reg;

    // walk window and position
    logic [CW-1:0] x0_reg, x1_reg, col_reg;
    logic [RW-1:0] y0_reg, y1_reg, row_reg;
    logic [AW-1:0] addr_reg;
    mul_res_t      acc_reg, rr_reg;
    logic [31:0]   pix_reg, newpix_reg;
    logic [1:0]    ch_reg;
    logic [31:0]   res_data_reg;
    logic          res_in_reg;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg;
    logic          m_in_reg;

    logic [31:0] mem [DEPTH];

    // effective image size, saturated at the store bounds
    logic [10:0]   wid11, hgt11;
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    always_comb begin
        wid11 = {4'd0, width_cfg_reg};
        hgt11 = {4'd0, height_cfg_reg};
        eff_w = (wid11 > 11'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : wid11[CW-1:0];
        eff_h = (hgt11 > 11'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : hgt11[RW-1:0];
    end

    // clip one axis: [start, start+len) against [0, lim)
    logic signed [17:0] xs, xe, ys, ye, wl, hl;
    logic [CW-1:0] cx0, cx1;
    logic [RW-1:0] cy0, cy1;

    always_comb begin
        wl = 18'(eff_w);
        hl = 18'(eff_h);
        unique case (kind_reg)
            KIND_RECT: begin
                xs = 18'(x_reg);
                ys = 18'(y_reg);
                xe = 18'(x_reg) + 18'(rw_reg);
                ye = 18'(y_reg) + 18'(rh_reg);
            end
            KIND_CIRC: begin
                xs = '0;
                ys = '0;
                xe = wl;
                ye = hl;
            end
            default: begin
                xs = 18'(x_reg);
                ys = 18'(y_reg);
                xe = 18'(x_reg) + 18'sd1;
                ye = 18'(y_reg) + 18'sd1;
            end
        endcase
        cx0 = (xs < 0) ? '0 : ((xs > wl) ? eff_w : xs[CW-1:0]);
        cx1 = (xe < 0) ? '0 : ((xe > wl) ? eff_w : xe[CW-1:0]);
        cy0 = (ys < 0) ? '0 : ((ys > hl) ? eff_h : ys[RW-1:0]);
        cy1 = (ye < 0) ? '0 : ((ye > hl) ? eff_h : ye[RW-1:0]);
    end

    // shared multiplier, operands chosen by the sequencer
    mul_op_t  mul_a, mul_b;
    mul_res_t mul_p;
    logic [7:0]  ch_f, ch_b, alpha;
    logic [8:0]  ch_d;
    logic [15:0] ch_v;
    logic signed [17:0] dxv, dyv;

    always_comb begin
        alpha = color_reg[7:0];
        ch_f  = color_reg[8*ch_reg +: 8];
        ch_b  = pix_reg[8*ch_reg +: 8];
        ch_d  = {1'b0, ch_f} - {1'b0, ch_b};
        dxv   = 18'($signed({1'b0, col_reg})) - 18'(x_reg);
        dyv   = 18'($signed({1'b0, row_reg})) - 18'(y_reg);
        unique case (state_reg)
            ST_SETUP: begin
                mul_a = 18'($signed({1'b0, rad_reg}));
                mul_b = 18'($signed({1'b0, rad_reg}));
            end
            ST_DX: begin
                mul_a = dxv;
                mul_b = dxv;
            end
            ST_DY: begin
                mul_a = dyv;
                mul_b = dyv;
            end
            ST_ADDR: begin
                mul_a = 18'($signed({1'b0, row_reg}));
                mul_b = 18'($signed({1'b0, eff_w}));
            end
            ST_CH: begin
                mul_a = 18'($signed({1'b0, alpha}));
                mul_b = 18'($signed(ch_d));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        // a*(f-b) + 255*b, always within 0..65025
        ch_v  = mul_p[15:0] + {ch_b, 8'd0} - {8'd0, ch_b};
    end

    mul_res_t     dist_sum;
    logic [CW:0]  col_inc;
    logic [RW:0]  row_inc;
    logic         walk_last;
    logic         region_empty;

    always_comb begin
        dist_sum     = acc_reg + mul_p;
        col_inc      = {1'b0, col_reg} + 1'b1;
        row_inc      = {1'b0, row_reg} + 1'b1;
        walk_last    = (row_inc >= {1'b0, y1_reg}) && (col_inc >= {1'b0, x1_reg});
        region_empty = (cx0 >= cx1) || (cy0 >= cy1);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_SETUP;
            ST_SETUP: begin
                if (region_empty)            state_next = ST_DONE;
                else if (kind_reg == KIND_CIRC) state_next = ST_DX;
                else                         state_next = ST_ADDR;
            end
            ST_DX:   state_next = ST_DY;
            ST_DY:   state_next = (dist_sum <= rr_reg) ? ST_ADDR : ST_NEXT;
            ST_ADDR: state_next = ST_RD;
            ST_RD:   state_next = (kind_reg == KIND_READ) ? ST_DONE : ST_CH;
            ST_CH:   if (ch_reg == 2'd3) state_next = ST_WR;
            ST_WR:   state_next = ST_NEXT;
            ST_NEXT: begin
                if (walk_last)                  state_next = ST_DONE;
                else if (kind_reg == KIND_CIRC) state_next = ST_DX;
                else                            state_next = ST_ADDR;
            end
            ST_DONE: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            width_cfg_reg  <= 7'd64;
            height_cfg_reg <= 7'd64;
            m_valid_reg    <= 1'b0;
            ch_reg         <= 2'd1;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index == REG_IMAGE_WIDTH) width_cfg_reg  <= cfg_wr_data;
                else                              height_cfg_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_SETUP: begin
                    col_reg <= cx0;
                    row_reg <= cy0;
                end
                ST_RD:  ch_reg <= 2'd1;
                ST_CH:  ch_reg <= ch_reg + 1'b1;
                ST_NEXT: begin
                    // column outer, row inner
                    if (row_inc < {1'b0, y1_reg}) begin
                        row_reg <= row_inc[RW-1:0];
                    end else begin
                        row_reg <= y0_reg;
                        col_reg <= walk_last ? '0 : col_inc[CW-1:0];
                    end
                    if (walk_last) row_reg <= '0;
                end
                ST_DONE: begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg  <= s_kind;
            x_reg     <= s_x_pos;
            y_reg     <= s_y_pos;
            rw_reg    <= s_rect_width;
            rh_reg    <= s_rect_height;
            rad_reg   <= s_radius;
            color_reg <= s_color;
        end
        unique case (state_reg)
            ST_SETUP: begin
                x0_reg       <= cx0;
                x1_reg       <= cx1;
                y0_reg       <= cy0;
                y1_reg       <= cy1;
                rr_reg       <= mul_p;
                res_data_reg <= '0;
                res_in_reg   <= 1'b0;
            end
            ST_DX:   acc_reg <= mul_p;
            ST_ADDR: addr_reg <= mul_p[AW-1:0] + AW'(col_reg);
            ST_RD: begin
                newpix_reg <= 32'd255;
                if (kind_reg == KIND_READ) begin
                    res_data_reg <= mem[addr_reg];
                    res_in_reg   <= 1'b1;
                end
            end
            ST_CH:   newpix_reg[8*ch_reg +: 8] <= div255(ch_v);
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg <= res_data_reg;
                    m_in_reg   <= res_in_reg;
                end
            end
            default: ;
        endcase
    end

    // frame memory: one write port; registered reads here and in the read command path
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            mem[clr_reg] <= '0;
        end else if (state_reg == ST_WR) begin
            mem[addr_reg] <= newpix_reg;
        end
        pix_reg <= mem[addr_reg];
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = m_data_reg;
    assign m_read_in_range = m_in_reg;

`ifndef SYNTHESIS
    // no command taken while the memory sweep runs
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("command accepted during memory clear");

    // blend walks colour channels 1..3 only, never the alpha byte
    a_channel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CH |-> ch_reg != 2'd0)
        else $error("blend channel index out of range");

    // walk position stays inside the clipped window
    a_walk_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADDR || state_reg == ST_WR) |->
        (col_reg < x1_reg && row_reg < y1_reg && col_reg >= x0_reg))
        else $error("walk position left the window");

    // a finished command always reaches the output register
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("result not loaded");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for blended_raster_fill: drives draw and read commands
// on the valid/ready channels and predicts every pixel reply. Depends on brf_pkg.
`timescale 1ns / 100ps

module tb;
    import brf_pkg::*;

    typedef struct {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        rw;
        logic [14:0]        rh;
        logic [14:0]        rad;
        logic [31:0]        color;
    } draw_cmd_t;

    typedef struct {
        logic [31:0] data;
        logic        in_range;
    } pixel_reply_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = REG_IMAGE_WIDTH;
    logic [6:0]         cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_BLEND;
    logic signed [15:0] s_x_pos = '0;
    logic signed [15:0] s_y_pos = '0;
    logic [14:0]        s_rect_width = '0;
    logic [14:0]        s_rect_height = '0;
    logic [14:0]        s_radius = '0;
    logic [31:0]        s_color = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_read_data;
    logic               m_read_in_range;

    blended_raster_fill i_dut (.*);

    // Shadow copy of the frame and the size registers.
    logic [31:0]  shadow_frame [4096];
    logic [6:0]   shadow_width = 7'd64;
    logic [6:0]   shadow_height = 7'd64;

    draw_cmd_t    pending_cmds [$];
    pixel_reply_t expected_replies [$];
    draw_cmd_t    offered_cmd;
    int           idle_mode = 0;   // 0: sender light, receiver heavy; 1: swapped; 2: none
    int           mismatch_count = 0;
    bit           pressure_req = 1'b0;
    bit           pressure_done = 1'b0;
    int           hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int used_width();
        return (shadow_width > 7'd64) ? 64 : int'(shadow_width);
    endfunction

    function automatic int used_height();
        return (shadow_height > 7'd64) ? 64 : int'(shadow_height);
    endfunction

    function automatic bit on_image(int x, int y);
        return x >= 0 && x < used_width() && y >= 0 && y < used_height();
    endfunction

    function automatic int pixel_slot(int x, int y);
        return (y * used_width() + x) % 4096;
    endfunction

    // Blend fg over bg for red, green and blue; alpha comes out opaque.
    function automatic logic [31:0] alpha_mix(logic [31:0] fg, logic [31:0] bg);
        int          a;
        int          c;
        logic [31:0] res;
        a = int'(fg[7:0]);
        res = 32'h0000_00FF;
        for (int sh = 8; sh < 32; sh += 8) begin
            c = (a * int'(fg[sh +: 8]) + (255 - a) * int'(bg[sh +: 8])) / 255;
            res[sh +: 8] = c[7:0];
        end
        return res;
    endfunction

    function automatic void paint_pixel(int x, int y, logic [31:0] color);
        int slot;
        if (on_image(x, y)) begin
            slot = pixel_slot(x, y);
            shadow_frame[slot] = alpha_mix(color, shadow_frame[slot]);
        end
    endfunction

    // Apply one command to the shadow frame and return the reply it yields.
    function automatic pixel_reply_t raster_predict(draw_cmd_t c);
        pixel_reply_t rep;
        int           x;
        int           y;
        int           x0;
        int           y0;
        int           x1;
        int           y1;
        longint       rr;
        longint       dx;
        longint       dy;
        x = int'(c.x);
        y = int'(c.y);
        rep.data = '0;
        rep.in_range = 1'b0;
        case (c.kind)
            KIND_BLEND: paint_pixel(x, y, c.color);
            KIND_RECT: begin
                x0 = x < 0 ? 0 : x;
                y0 = y < 0 ? 0 : y;
                x1 = (x + int'(c.rw)) < used_width() ? x + int'(c.rw) : used_width();
                y1 = (y + int'(c.rh)) < used_height() ? y + int'(c.rh) : used_height();
                for (int i = x0; i < x1; i++)
                    for (int j = y0; j < y1; j++)
                        paint_pixel(i, j, c.color);
            end
            KIND_CIRC: begin
                rr = longint'(c.rad) * longint'(c.rad);
                for (int i = 0; i < used_width(); i++)
                    for (int j = 0; j < used_height(); j++) begin
                        dx = longint'(i) - x;
                        dy = longint'(j) - y;
                        if (dx * dx + dy * dy <= rr)
                            paint_pixel(i, j, c.color);
                    end
            end
            default: begin
                if (on_image(x, y)) begin
                    rep.data = shadow_frame[pixel_slot(x, y)];
                    rep.in_range = 1'b1;
                end
            end
        endcase
        return rep;
    endfunction

    // ---------------------------------------------------------------- driver

    function automatic bit sender_idles();
        if (idle_mode == 0) return $urandom_range(0, 99) < 27;
        if (idle_mode == 1) return $urandom_range(0, 99) < 84;
        return 1'b0;
    endfunction

    function automatic bit receiver_idles();
        if (idle_mode == 0) return $urandom_range(0, 99) < 84;
        if (idle_mode == 1) return $urandom_range(0, 99) < 27;
        return 1'b0;
    endfunction

    // Predict on acceptance; load the next command only once the current
    // transaction has gone through, so valid and payload hold while stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_replies.push_back(raster_predict(offered_cmd));
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0 && !sender_idles()) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_kind        <= offered_cmd.kind;
                    s_x_pos       <= offered_cmd.x;
                    s_y_pos       <= offered_cmd.y;
                    s_rect_width  <= offered_cmd.rw;
                    s_rect_height <= offered_cmd.rh;
                    s_radius      <= offered_cmd.rad;
                    s_color       <= offered_cmd.color;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Long receiver hold-off so the engine fills up and drops s_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (pressure_req && !pressure_done) begin
            hold_left <= 3000;
            pressure_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        pixel_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $error("reply with none expected: read_data %h read_in_range %b",
                       m_read_data, m_read_in_range);
                mismatch_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_read_data !== want.data) begin
                    $error("read_data: expected %h, got %h", want.data, m_read_data);
                    mismatch_count++;
                end
                if (m_read_in_range !== want.in_range) begin
                    $error("read_in_range: expected %b, got %b",
                           want.in_range, m_read_in_range);
                    mismatch_count++;
                end
            end
        end
        m_ready <= aresetn && hold_left == 0 && !receiver_idles();
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void add_cmd(logic [1:0] kind, int x, int y, int rw, int rh,
                                    int rad, logic [31:0] color);
        draw_cmd_t c;
        c.kind = kind;
        c.x = x[15:0];
        c.y = y[15:0];
        c.rw = rw[14:0];
        c.rh = rh[14:0];
        c.rad = rad[14:0];
        c.color = color;
        pending_cmds.push_back(c);
    endfunction

    function automatic int pick_coord(int span);
        if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, span + 5)) - 2;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_extent(int span);
        if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, span + 2));
        return int'($urandom_range(0, 32767));
    endfunction

    // Draws mixed with plenty of reads so painted pixels get read back.
    function automatic void add_random(int count);
        int span;
        int sel;
        logic [1:0] kind;
        span = used_width() > used_height() ? used_width() : used_height();
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            kind = sel < 40 ? KIND_READ : sel < 65 ? KIND_BLEND :
                   sel < 83 ? KIND_RECT : KIND_CIRC;
            add_cmd(kind, pick_coord(span), pick_coord(span), pick_extent(span),
                    pick_extent(span), pick_extent(span / 2), $urandom());
        end
    endfunction

    // Let all queued commands go through and every reply come back.
    task automatic drain();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_replies.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [6:0] w, logic [6:0] h);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_IMAGE_WIDTH;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_index   <= REG_IMAGE_HEIGHT;
        cfg_wr_data <= h;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_width = w;
        shadow_height = h;
    endtask

    initial begin
        foreach (shadow_frame[k]) shadow_frame[k] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // hold configuration until the clearing sweep is over
        do @(posedge aclk); while (!s_ready);

        write_size(7'd64, 7'd64);
        idle_mode = 0;
        add_cmd(KIND_BLEND, 0, 0, 0, 0, 0, 32'hFF80_40FF);
        add_cmd(KIND_READ, 0, 0, 0, 0, 0, 32'h0);
        add_cmd(KIND_BLEND, 0, 0, 0, 0, 0, 32'h1234_5600);
        add_cmd(KIND_READ, 0, 0, 32767, 32767, 32767, 32'hFFFF_FFFF);
        add_cmd(KIND_BLEND, 63, 63, 32767, 32767, 32767, 32'hFFFF_FF80);
        add_cmd(KIND_READ, 63, 63, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, -1, 0, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, 64, 0, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, 0, 64, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, -32768, 32767, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, 32767, -32768, 0, 0, 0, 32'h0);
        add_cmd(KIND_RECT, -3, -3, 5, 4, 0, 32'h00FF_00C0);
        add_cmd(KIND_READ, 1, 0, 0, 0, 0, 32'h0);
        add_cmd(KIND_RECT, 5, 5, 0, 10, 0, 32'hFFFF_FFFF);
        add_cmd(KIND_RECT, 5, 5, 10, 0, 0, 32'hFFFF_FFFF);
        add_cmd(KIND_RECT, 60, 60, 32767, 32767, 0, 32'hFFFF_FFFF);
        add_cmd(KIND_READ, 63, 63, 0, 0, 0, 32'h0);
        add_cmd(KIND_CIRC, 10, 10, 0, 0, 0, 32'hA5A5_A57F);
        add_cmd(KIND_READ, 10, 10, 0, 0, 0, 32'h0);
        add_cmd(KIND_READ, 11, 10, 0, 0, 0, 32'h0);
        add_cmd(KIND_CIRC, -5, 70, 0, 0, 32767, 32'h0000_FF01);
        add_cmd(KIND_READ, 30, 30, 0, 0, 0, 32'h0);
        drain();

        // register values past the store saturate at full size
        write_size(7'd127, 7'd127);
        add_random(6);
        drain();
        write_size(7'd0, 7'd9);
        add_random(8);
        drain();
        write_size(7'd9, 7'd0);
        add_random(6);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            idle_mode = phase / 2;
            write_size(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
            add_random(15);
            if (phase == 4) pressure_req = 1'b1;
            drain();
        end

        write_size(7'd1, 7'd1);
        add_random(6);
        drain();
        write_size(7'd64, 7'd1);
        add_random(4);
        drain();

        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: blended_raster_fill.f
design/brf_pkg.sv
design/blended_raster_fill.sv
tb/sv/tb.sv
